### hdl/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg: shared types and constants of the k-NN cosine vote classifier
// Token formats carried along the cell chain and result status codes.
// ----------------------------------------------------------------------------
package knn_pkg;

  localparam int VAL_W  = 16;  // Q8.8 element
  localparam int IDX_W  = 12;  // element position within a vector
  localparam int TGT_W  = 10;  // entry number, up to 1024 entries
  localparam int CNT_W  = 11;  // entry count, 0..1024
  localparam int NORM_W = 24;
  localparam int LAB_W  = 4;
  localparam int DOT_W  = 48;
  localparam int SQ_W   = 48;
  localparam int K_W    = 5;
  localparam int ST_W   = 2;
  localparam int VOTE_W = 5;
  localparam int K_MAX  = 16;
  localparam int MUL_W  = 24;  // half of a magnitude word
  localparam int PRD_W  = 72;  // full cross product

  // Operation carried by a data-chain token
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_STORE = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLOSE = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_ANSWERED = 2'd0,
    ST_STORED   = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // Element token, moves one cell per cycle
  typedef struct packed {
    op_e                     op;
    logic                    clear;   // first element of a vector
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        idx;
    logic [TGT_W-1:0]        target;  // entry written by store / close
    logic [NORM_W-1:0]       norm;
    logic [LAB_W-1:0]        label;
  } dtok_t;

  // Ranking token: best candidate seen so far in this round
  typedef struct packed {
    logic                    valid;
    logic                    has;
    logic signed [DOT_W-1:0] dot;
    logic [NORM_W-1:0]       norm;
    logic [TGT_W-1:0]        idx;
    logic [LAB_W-1:0]        label;
  } rtok_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic             clr_chosen;
    logic             mark;
    logic [TGT_W-1:0] mark_idx;
    logic [CNT_W-1:0] count;
  } rctl_t;

endpackage

### hdl/knn_intf.sv
// ----------------------------------------------------------------------------
// knn_intf: handshake channels of the k-NN classifier
// Element input, result output and the k_neighbors write channel.
// ----------------------------------------------------------------------------
interface knn_item_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic signed [15:0] value;
  logic [3:0]        label;
  logic              last;
  modport source (output valid, cmd, value, label, last, input ready);
  modport sink   (input valid, cmd, value, label, last, output ready);
endinterface

interface knn_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] best_label;
  logic [4:0] votes;
  modport source (output valid, status, best_label, votes, input ready);
  modport sink   (input valid, status, best_label, votes, output ready);
endinterface

interface knn_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### hdl/knn_isqrt.sv
// ----------------------------------------------------------------------------
// knn_isqrt: iterative integer square root
// One result bit per cycle, floor(sqrt) of a 48-bit sum of squares.
// ----------------------------------------------------------------------------
module knn_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [knn_pkg::SQ_W-1:0]      radicand_i,
  output logic                          done_o,
  output logic [knn_pkg::NORM_W-1:0]    root_o
);
  localparam int W = knn_pkg::SQ_W;

  logic [W-1:0] x_q, res_q, bit_q, sum;
  logic         busy_q, done_q;

  assign sum    = res_q + bit_q;
  assign done_o = done_q;
  assign root_o = res_q[knn_pkg::NORM_W-1:0];

  // digit-by-digit root, two radicand bits per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      x_q    <= '0;
      res_q  <= '0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        x_q    <= radicand_i;
        res_q  <= '0;
        bit_q  <= {2'b01, {(W-2){1'b0}}};
      end else if (busy_q) begin
        if (bit_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          if (x_q >= sum) begin
            x_q   <= x_q - sum;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
      end
    end
  end
endmodule

### hdl/knn_cell.sv
// ----------------------------------------------------------------------------
// knn_cell: one stored entry of the classifier chain
// Holds the entry's vector, norm, label and dot product; compares itself
// against the ranking token and passes both tokens to its right neighbor.
// ----------------------------------------------------------------------------
module knn_cell #(
  parameter int DIM = 4096,
  parameter int ID  = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  knn_pkg::dtok_t  dtok_i,
  output knn_pkg::dtok_t  dtok_o,
  input  knn_pkg::rtok_t  rtok_i,
  output knn_pkg::rtok_t  rtok_o,
  input  knn_pkg::rctl_t  rctl_i
);
  localparam int AW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int TW = knn_pkg::TGT_W;
  localparam int CW = knn_pkg::CNT_W;
  localparam int DW = knn_pkg::DOT_W;
  localparam int NW = knn_pkg::NORM_W;
  localparam int MW = knn_pkg::MUL_W;
  localparam int PW = knn_pkg::PRD_W;

  logic signed [15:0] mem_q [DIM];

  knn_pkg::dtok_t     tok_q;
  logic [AW-1:0]      addr;
  logic               hit;
  logic signed [15:0] rd_q, v1_q;
  logic               qry1_q, clr1_q, qry2_q, clr2_q;
  logic signed [31:0] prod_q;
  logic signed [DW-1:0] acc_q;
  logic [NW-1:0]      norm_q;
  logic [3:0]         label_q;
  logic               chosen_q;

  assign addr   = tok_q.idx[AW-1:0];
  assign hit    = (tok_q.target == TW'(ID));
  assign dtok_o = tok_q;

  // element token register, handed on to the neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '{op: knn_pkg::OP_NONE, default: '0};
    end else begin
      tok_q <= dtok_i;
    end
  end

  // vector memory, product and entry attributes
  always_ff @(posedge clk_i) begin
    if (tok_q.op == knn_pkg::OP_STORE && hit) begin
      mem_q[addr] <= tok_q.value;
    end
    rd_q   <= mem_q[addr];
    v1_q   <= tok_q.value;
    prod_q <= v1_q * rd_q;
    if (tok_q.op == knn_pkg::OP_CLOSE && hit) begin
      norm_q  <= tok_q.norm;
      label_q <= tok_q.label;
    end
  end

  // dot product accumulation, cleared on the first element of a vector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qry1_q <= 1'b0;
      clr1_q <= 1'b0;
      qry2_q <= 1'b0;
      clr2_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      qry1_q <= (tok_q.op == knn_pkg::OP_QUERY);
      clr1_q <= tok_q.clear;
      qry2_q <= qry1_q;
      clr2_q <= clr1_q;
      if (clr2_q) begin
        acc_q <= qry2_q ? DW'(prod_q) : '0;
      end else if (qry2_q) begin
        acc_q <= acc_q + DW'(prod_q);
      end
    end
  end

  // ---- ranking ----
  logic                 own_zero, elig;
  logic signed [DW-1:0] own_dot;
  logic [NW-1:0]        own_norm;
  knn_pkg::rtok_t       own_tok, cand_q, rout_q;
  logic [2:0]           step_q;
  logic [DW-1:0]        ux_q, uy_q;
  logic                 nx_q, ny_q, above;
  logic [NW-1:0]        m_q, n_q;
  logic [DW-1:0]        plx_q, ply_q, phx_q, phy_q;
  logic [PW-1:0]        sx_q, sy_q;

  // zero-norm entry behaves as dot 0 over norm 1
  assign own_zero = (norm_q == '0);
  assign own_dot  = own_zero ? '0 : acc_q;
  assign own_norm = own_zero ? NW'(1) : norm_q;
  assign elig     = (CW'(ID) < rctl_i.count) && !chosen_q;
  assign own_tok  = '{valid: 1'b1, has: 1'b1, dot: own_dot, norm: own_norm,
                      idx: TW'(ID), label: label_q};
  assign rtok_o   = rout_q;

  // own above candidate when own_dot*cand_norm > cand_dot*own_norm
  always_comb begin
    if (nx_q != ny_q) begin
      above = !nx_q;
    end else if (nx_q) begin
      above = (sx_q < sy_q);
    end else begin
      above = (sx_q > sy_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      rout_q   <= '0;
      cand_q   <= '0;
      chosen_q <= 1'b0;
    end else begin
      rout_q.valid <= 1'b0;
      if (rctl_i.clr_chosen) begin
        chosen_q <= 1'b0;
      end else if (rctl_i.mark && rctl_i.mark_idx == TW'(ID)) begin
        chosen_q <= 1'b1;
      end
      if (rtok_i.valid) begin
        cand_q <= rtok_i;
        step_q <= 3'd1;
      end else begin
        case (step_q)
          3'd1: begin
            if (!elig) begin
              rout_q <= cand_q;
              step_q <= '0;
            end else if (!cand_q.has) begin
              rout_q <= own_tok;
              step_q <= '0;
            end else begin
              step_q <= 3'd2;
            end
          end
          3'd2, 3'd3, 3'd4: step_q <= step_q + 3'd1;
          3'd5: begin
            rout_q <= above ? own_tok : cand_q;
            step_q <= '0;
          end
          default: step_q <= '0;
        endcase
      end
    end
  end

  // cross-product datapath: magnitudes, low and high partial products, sum
  always_ff @(posedge clk_i) begin
    if (step_q == 3'd1) begin
      ux_q <= own_dot[DW-1] ? DW'(-own_dot) : DW'(own_dot);
      uy_q <= cand_q.dot[DW-1] ? DW'(-cand_q.dot) : DW'(cand_q.dot);
      nx_q <= own_dot[DW-1];
      ny_q <= cand_q.dot[DW-1];
      m_q  <= cand_q.norm;
      n_q  <= own_norm;
    end
    if (step_q == 3'd2) begin
      plx_q <= ux_q[MW-1:0] * m_q;
      ply_q <= uy_q[MW-1:0] * n_q;
    end
    if (step_q == 3'd3) begin
      phx_q <= ux_q[DW-1:MW] * m_q;
      phy_q <= uy_q[DW-1:MW] * n_q;
    end
    if (step_q == 3'd4) begin
      sx_q <= {phx_q, {MW{1'b0}}} + PW'(plx_q);
      sy_q <= {phy_q, {MW{1'b0}}} + PW'(ply_q);
    end
  end
endmodule

### hdl/knn_cosine_vote_classifier.sv
// ----------------------------------------------------------------------------
// knn_cosine_vote_classifier: k-NN classifier, cosine similarity, label vote
// Chain of entry cells with a central sequencer, norm unit and vote tally.
// ----------------------------------------------------------------------------
// Usage:
//   item_i carries one vector element per transaction (cmd 0 store, 1 query,
//   last closes the vector). result_o carries one transaction per closed
//   vector: status, winning label and its vote count. cfg_i writes
//   k_neighbors at any time the block is idle; it is always ready.
// Flow:
//   Every element travels the chain of ENTRIES cells, and the next one is
//   taken only after it has passed. Closing a stored entry adds a
//   bit-serial square root. Closing a query adds K ranking rounds, each a
//   pass of the candidate token through all cells (longer at a cell that
//   runs its cross-product compare), then a scan of the label tally.
// Reset:
//   Entry count, element position and k_neighbors (10) are restored; stored
//   vectors are left as they are and become unreachable.
// Stalls:
//   The result sits in an output register; the next element is accepted
//   while it waits. A new result waits for that register to empty.
// ----------------------------------------------------------------------------
module knn_cosine_vote_classifier #(
  parameter int ENTRIES = 64,
  parameter int DIM     = 4096,
  parameter int LABELS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  knn_item_if.sink          item_i,
  knn_result_if.source      result_o,
  knn_cfg_if.sink           cfg_i
);
  localparam int EW   = $clog2(DIM + 1);
  localparam int NT   = (LABELS < 16) ? LABELS : 16;
  localparam int VW   = $clog2(NT);
  localparam int FLOW = ENTRIES + 4;
  localparam int FW   = $clog2(FLOW + 1);
  localparam int TW   = knn_pkg::TGT_W;
  localparam int CW   = knn_pkg::CNT_W;
  localparam int KW   = knn_pkg::K_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FLOW  = 7'b0000010,
    S_SQRT  = 7'b0000100,
    S_RANK  = 7'b0001000,
    S_RWAIT = 7'b0010000,
    S_VOTE  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  state_e                  state_q;
  logic [EW-1:0]           eidx_q;
  logic [CW-1:0]           count_q;
  logic [knn_pkg::SQ_W-1:0] sq_q;
  logic [KW-1:0]           k_q, keff_q, round_q, kk;
  logic                    last_q, cmd_q;
  logic [3:0]              lab_q, lab_in;
  logic [FW-1:0]           cnt_q;
  logic [VW-1:0]           vl_q;
  logic [3:0]              best_lab_q;
  logic [4:0]              best_votes_q;
  logic [4:0]              tally_q [NT];
  knn_pkg::status_e        st_q;
  logic                    out_valid_q;
  logic [1:0]              out_status_q;
  logic [3:0]              out_label_q;
  logic [4:0]              out_votes_q;
  logic                    accept, full, sqrt_start, sqrt_done;
  logic signed [31:0]      sqr;
  logic [knn_pkg::NORM_W-1:0] root;

  knn_pkg::dtok_t launch_q;
  knn_pkg::rtok_t rlaunch_q;
  knn_pkg::rctl_t rctl;
  knn_pkg::dtok_t dchain [ENTRIES+1];
  knn_pkg::rtok_t rchain [ENTRIES+1];

  assign accept       = item_i.valid && item_i.ready;
  assign item_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign full         = (count_q >= CW'(ENTRIES));
  assign sqr          = item_i.value * item_i.value;
  assign lab_in       = ({1'b0, item_i.label} >= 5'(NT)) ? 4'(NT - 1) : item_i.label;
  assign sqrt_start   = (state_q == S_FLOW) && (cnt_q == '0) && last_q && !cmd_q && !full;

  // K clamped to 1..16; keff_q later limits it to the stored entries
  always_comb begin
    if (k_q == '0) begin
      kk = KW'(1);
    end else if (k_q > KW'(knn_pkg::K_MAX)) begin
      kk = KW'(knn_pkg::K_MAX);
    end else begin
      kk = k_q;
    end
  end

  // broadcast control to the cells
  always_comb begin
    rctl.clr_chosen = (state_q == S_RANK) && (round_q == '0);
    rctl.mark       = (state_q == S_RWAIT) && rchain[ENTRIES].valid;
    rctl.mark_idx   = rchain[ENTRIES].idx;
    rctl.count      = count_q;
  end

  assign dchain[0] = launch_q;
  assign rchain[0] = rlaunch_q;

  // the chain of entry cells
  for (genvar e = 0; e < ENTRIES; e++) begin : g_cell
    knn_cell #(.DIM(DIM), .ID(e)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .dtok_i (dchain[e]),
      .dtok_o (dchain[e+1]),
      .rtok_i (rchain[e]),
      .rtok_o (rchain[e+1]),
      .rctl_i (rctl)
    );
  end

  knn_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sq_q),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= KW'(10);
    end else if (cfg_i.valid) begin
      k_q <= cfg_i.data;
    end
  end

  // label tally
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NT; l++) begin
      if (state_q == S_RANK && round_q == '0) begin
        tally_q[l] <= '0;
      end else if (rctl.mark && rchain[ENTRIES].label == 4'(l)) begin
        tally_q[l] <= tally_q[l] + 5'd1;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      eidx_q       <= '0;
      count_q      <= '0;
      sq_q         <= '0;
      keff_q       <= '0;
      round_q      <= '0;
      last_q       <= 1'b0;
      cmd_q        <= 1'b0;
      lab_q        <= '0;
      cnt_q        <= '0;
      vl_q         <= '0;
      best_lab_q   <= '0;
      best_votes_q <= '0;
      st_q         <= knn_pkg::ST_ANSWERED;
      launch_q     <= '{op: knn_pkg::OP_NONE, default: '0};
      rlaunch_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_label_q  <= '0;
      out_votes_q  <= '0;
    end else begin
      launch_q        <= '{op: knn_pkg::OP_NONE, default: '0};
      rlaunch_q.valid <= 1'b0;
      if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            last_q <= item_i.last;
            cmd_q  <= item_i.cmd;
            lab_q  <= lab_in;
            cnt_q  <= FW'(FLOW - 1);
            state_q <= S_FLOW;
            if (eidx_q < EW'(DIM)) begin
              launch_q.clear  <= (eidx_q == '0);
              launch_q.value  <= item_i.value;
              launch_q.idx    <= knn_pkg::IDX_W'(eidx_q);
              launch_q.target <= TW'(count_q);
              if (item_i.cmd) begin
                launch_q.op <= knn_pkg::OP_QUERY;
              end else if (!full) begin
                launch_q.op <= knn_pkg::OP_STORE;
                sq_q <= sq_q + {16'b0, sqr};
              end
              eidx_q <= eidx_q + EW'(1);
            end
            if (item_i.last) begin
              eidx_q <= '0;
            end
          end
        end
        S_FLOW: begin
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - FW'(1);
          end else if (!last_q) begin
            state_q <= S_IDLE;
          end else if (!cmd_q) begin
            if (full) begin
              st_q    <= knn_pkg::ST_FULL;
              sq_q    <= '0;
              state_q <= S_EMIT;
            end else begin
              state_q <= S_SQRT;
            end
          end else begin
            sq_q <= '0;
            if (count_q == '0) begin
              st_q    <= knn_pkg::ST_EMPTY;
              state_q <= S_EMIT;
            end else begin
              keff_q  <= (CW'(kk) > count_q) ? count_q[KW-1:0] : kk;
              round_q <= '0;
              state_q <= S_RANK;
            end
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            launch_q.op     <= knn_pkg::OP_CLOSE;
            launch_q.target <= TW'(count_q);
            launch_q.norm   <= root;
            launch_q.label  <= lab_q;
            count_q <= count_q + CW'(1);
            sq_q    <= '0;
            st_q    <= knn_pkg::ST_STORED;
            state_q <= S_EMIT;
          end
        end
        S_RANK: begin
          rlaunch_q <= '{valid: 1'b1, default: '0};
          state_q   <= S_RWAIT;
        end
        S_RWAIT: begin
          if (rchain[ENTRIES].valid) begin
            round_q <= round_q + KW'(1);
            if (round_q == keff_q - KW'(1)) begin
              vl_q         <= '0;
              best_lab_q   <= '0;
              best_votes_q <= '0;
              state_q      <= S_VOTE;
            end else begin
              state_q <= S_RANK;
            end
          end
        end
        S_VOTE: begin
          // strict compare keeps the lowest label on equal votes
          if (tally_q[vl_q] > best_votes_q) begin
            best_votes_q <= tally_q[vl_q];
            best_lab_q   <= 4'(vl_q);
          end
          if (vl_q == VW'(NT - 1)) begin
            st_q    <= knn_pkg::ST_ANSWERED;
            state_q <= S_EMIT;
          end else begin
            vl_q <= vl_q + VW'(1);
          end
        end
        S_EMIT: begin
          if (!out_valid_q || result_o.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= st_q;
            out_label_q  <= (st_q == knn_pkg::ST_ANSWERED) ? best_lab_q : '0;
            out_votes_q  <= (st_q == knn_pkg::ST_ANSWERED) ? best_votes_q : '0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.status     = out_status_q;
  assign result_o.best_label = out_label_q;
  assign result_o.votes      = out_votes_q;
endmodule

### hdl/knn_checker.sv
// ----------------------------------------------------------------------------
// knn_checker: port-level checks of the k-NN classifier result channel
// Bound to the top level; looks at its result port only.
// ----------------------------------------------------------------------------
module knn_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] status_i,
  input logic [3:0] best_label_i,
  input logic [4:0] votes_i
);
  // a pending result stays until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i))
    else $error("result dropped or changed while stalled");

  // only an answered query carries a label and votes
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != knn_pkg::ST_ANSWERED |->
      best_label_i == 4'd0 && votes_i == 5'd0)
    else $error("label or votes on a non-query result");

  // an answered query has at least one and at most sixteen votes
  a_votes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == knn_pkg::ST_ANSWERED |->
      votes_i != 5'd0 && votes_i <= 5'd16)
    else $error("vote count out of range");

  // no result right after reset
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid after reset");
endmodule

bind knn_cosine_vote_classifier knn_checker u_knn_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .status_i     (result_o.status),
  .best_label_i (result_o.best_label),
  .votes_i      (result_o.votes)
);

### tb/tb_knn_cosine_vote_classifier.sv
// ----------------------------------------------------------------------------
// tb_knn_cosine_vote_classifier: self-checking bench of the k-NN classifier
// Drives store, query and mixed element streams with random idling and
// backpressure. A scoreboard model ranks entries by cosine similarity and
// votes, and each result transaction is compared field by field with it.
// ----------------------------------------------------------------------------
module tb_knn_cosine_vote_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENTRIES = 64;
  localparam int VEC_DIM     = 32;
  localparam int NUM_LABELS  = 16;
  localparam int SETTLE_CYC  = 200;
  localparam int STALL_LIMIT = 60000;
  localparam bit CMD_STORE   = 1'b0;
  localparam bit CMD_QUERY   = 1'b1;

  typedef struct {
    knn_pkg::status_e status;
    logic [3:0]       label;
    logic [4:0]       votes;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  knn_item_if   item_if ();
  knn_result_if res_if ();
  knn_cfg_if    cfg_if ();

  knn_cosine_vote_classifier #(
    .ENTRIES (NUM_ENTRIES),
    .DIM     (VEC_DIM),
    .LABELS  (NUM_LABELS)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Scoreboard copy of the classifier state
  shortint         vec_mem [NUM_ENTRIES][VEC_DIM];
  bit              wr_map [NUM_ENTRIES][VEC_DIM];
  logic [3:0]      class_mem [NUM_ENTRIES];
  longint          norm_mem [NUM_ENTRIES];
  longint          dot_acc [NUM_ENTRIES];
  int              written_len [NUM_ENTRIES];  // length of the written prefix
  int              n_stored;
  int              elem_pos;
  longint unsigned energy_acc;
  int              k_setting;

  verdict_t        verdict_q[$];
  int              mismatches;
  int              items_sent;
  bit              no_idle;
  bit              hold_req;
  int              hold_cnt;
  int              quiet_cycles;

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Cosine order by cross products; a zero-norm entry counts as dot 0 / 1
  function automatic bit outranks(int a, int b);
    longint da = dot_acc[a];
    longint db = dot_acc[b];
    longint na = norm_mem[a];
    longint nb = norm_mem[b];
    logic signed [95:0] pa, pb;
    if (na == 0) begin
      da = 0;
      na = 1;
    end
    if (nb == 0) begin
      db = 0;
      nb = 1;
    end
    pa = da;
    pb = db;
    pa = pa * nb;
    pb = pb * na;
    return pa > pb;
  endfunction

  function automatic void classify_element(bit cmd, logic signed [15:0] v,
                                           logic [3:0] lab, bit last);
    verdict_t vd;
    bit       picked [NUM_ENTRIES];
    int       tally [NUM_LABELS];
    int       k, best, best_votes;
    vd = '{knn_pkg::ST_ANSWERED, 4'd0, 5'd0};
    if (elem_pos == 0) foreach (dot_acc[e]) dot_acc[e] = 0;
    if (elem_pos < VEC_DIM) begin
      if (cmd == CMD_STORE) begin
        if (n_stored < NUM_ENTRIES) begin
          vec_mem[n_stored][elem_pos] = v;
          energy_acc += longint'(v) * longint'(v);
          wr_map[n_stored][elem_pos] = 1'b1;
          while (written_len[n_stored] < VEC_DIM &&
                 wr_map[n_stored][written_len[n_stored]])
            written_len[n_stored]++;
        end
      end else begin
        for (int e = 0; e < n_stored; e++)
          dot_acc[e] += longint'(v) * longint'(vec_mem[e][elem_pos]);
      end
      elem_pos++;
    end
    if (!last) return;
    elem_pos = 0;
    if (cmd == CMD_STORE) begin
      if (n_stored >= NUM_ENTRIES) begin
        vd.status = knn_pkg::ST_FULL;
      end else begin
        norm_mem[n_stored]  = longint'(floor_root(energy_acc) & 64'hFF_FFFF);
        class_mem[n_stored] = lab;
        n_stored++;
        vd.status = knn_pkg::ST_STORED;
      end
      energy_acc = 0;
      verdict_q.insert(verdict_q.size(), vd);
      return;
    end
    energy_acc = 0;
    if (n_stored == 0) begin
      vd.status = knn_pkg::ST_EMPTY;
      verdict_q.insert(verdict_q.size(), vd);
      return;
    end
    // out-of-range K is clamped, then limited to the entry count
    k = k_setting;
    if (k < 1) k = 1;
    if (k > knn_pkg::K_MAX) k = knn_pkg::K_MAX;
    if (k > n_stored) k = n_stored;
    foreach (picked[e]) picked[e] = 1'b0;
    foreach (tally[l]) tally[l] = 0;
    for (int r = 0; r < k; r++) begin
      best = -1;
      for (int e = 0; e < n_stored; e++) begin
        if (picked[e]) continue;
        if (best < 0 || outranks(e, best)) best = e;
      end
      picked[best] = 1'b1;
      tally[class_mem[best]]++;
    end
    best_votes = 0;
    for (int l = 0; l < NUM_LABELS; l++) begin
      if (tally[l] > best_votes) begin
        best_votes = tally[l];
        vd.label   = 4'(l);
      end
    end
    vd.votes = 5'(best_votes);
    verdict_q.insert(verdict_q.size(), vd);
  endfunction

  // Shortest entry written so far; queries must stay within it
  function automatic int min_written();
    int m = VEC_DIM;
    for (int e = 0; e < n_stored; e++)
      if (written_len[e] < m) m = written_len[e];
    return m;
  endfunction

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(16)) - 8);
      2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'(int'($urandom_range(600)) - 300);
    endcase
  endfunction

  // Receiver: random idling plus one long counted hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (hold_req) begin
        hold_cnt = 3000;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= no_idle || ($urandom_range(99) >= 17);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d label %0d votes %0d",
                   res_if.status, res_if.best_label, res_if.votes);
      end else begin
        verdict_t vd;
        vd = verdict_q.pop_front();
        if (res_if.status !== vd.status || res_if.best_label !== vd.label ||
            res_if.votes !== vd.votes) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                     vd.status, vd.label, vd.votes,
                     res_if.status, res_if.best_label, res_if.votes);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_elem(bit cmd, logic signed [15:0] v, logic [3:0] lab, bit last);
    if (!no_idle) begin
      while ($urandom_range(99) < 17) begin
        item_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    item_if.valid <= 1'b1;
    item_if.cmd   <= cmd;
    item_if.value <= v;
    item_if.label <= lab;
    item_if.last  <= last;
    do @(posedge clk_i); while (!item_if.ready);
    classify_element(cmd, v, lab, last);
    items_sent++;
  endtask

  // Sender pause: everything expected has come and the block is quiet
  task automatic drain();
    item_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_k(logic [4:0] kval);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= kval;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    k_setting = kval;
  endtask

  task automatic store_vector(int len, logic [3:0] lab);
    for (int i = 0; i < len; i++) send_elem(CMD_STORE, rand_value(), lab, i == len - 1);
  endtask

  task automatic query_vector(int len);
    int n = len < min_written() ? len : min_written();
    for (int i = 0; i < n; i++) send_elem(CMD_QUERY, rand_value(), 4'($urandom), i == n - 1);
  endtask

  // Elements of both commands in one vector; the last one picks the action.
  // The first element stores, so every new entry has its first element.
  task automatic mixed_vector(int len);
    int n = len < min_written() ? len : min_written();
    for (int i = 0; i < n; i++)
      send_elem((i == 0) ? CMD_STORE : 1'($urandom), rand_value(), 4'($urandom),
                i == n - 1);
  endtask

  task automatic random_vector();
    int pick = $urandom_range(99);
    if (pick < 40)      store_vector($urandom_range(4, 8), 4'($urandom));
    else if (pick < 85) query_vector($urandom_range(1, 6));
    else                mixed_vector($urandom_range(1, 6));
  endtask

  task automatic test_empty_query();
    send_elem(CMD_QUERY, 16'sh7FFF, 4'd0, 1'b1);
  endtask

  task automatic test_extremes();
    send_elem(CMD_STORE, 16'sh7FFF, 4'd15, 1'b0);
    send_elem(CMD_STORE, 16'sh8000, 4'd15, 1'b0);
    send_elem(CMD_STORE, 16'sh7FFF, 4'd15, 1'b0);
    send_elem(CMD_STORE, 16'sh8000, 4'd15, 1'b1);
    for (int i = 0; i < 4; i++) send_elem(CMD_STORE, 16'sh0000, 4'd0, i == 3);  // zero norm
    for (int i = 0; i < 4; i++) send_elem(CMD_STORE, 16'sh8000, 4'd3, i == 3);
    for (int i = 0; i < 4; i++) send_elem(CMD_STORE, 16'(i + 1), 4'd3, i == 3);
    send_elem(CMD_QUERY, 16'sh7FFF, 4'd0, 1'b0);
    send_elem(CMD_QUERY, 16'sh7FFF, 4'd0, 1'b1);
    send_elem(CMD_QUERY, 16'sh0000, 4'd0, 1'b0);  // all-zero query ties everything
    send_elem(CMD_QUERY, 16'sh0000, 4'd0, 1'b1);
    send_elem(CMD_QUERY, 16'sh8000, 4'd0, 1'b0);
    send_elem(CMD_QUERY, 16'sh7FFF, 4'd0, 1'b1);
    send_elem(CMD_STORE, 16'sh0100, 4'd9, 1'b0);  // store element, query close
    send_elem(CMD_QUERY, 16'shFF00, 4'd9, 1'b1);
    send_elem(CMD_QUERY, 16'sh0040, 4'd9, 1'b0);  // query element, store close
    send_elem(CMD_STORE, 16'sh0040, 4'd9, 1'b1);
  endtask

  // Vector longer than DIM: extra elements dropped, index holds
  task automatic test_overlong_vector();
    for (int i = 0; i <= VEC_DIM; i++)
      send_elem(CMD_STORE, rand_value(), 4'd6, i == VEC_DIM);
    query_vector(4);
  endtask

  task automatic test_k_settings();
    logic [4:0] ks [6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd10};
    int stop;
    foreach (ks[i]) begin
      write_k(ks[i]);
      stop = items_sent + 15;
      while (items_sent < stop) random_vector();
    end
  endtask

  task automatic test_random_traffic();
    int stop = items_sent + 420;
    int calm = items_sent + 100;
    while (items_sent < stop) begin
      no_idle = (items_sent > calm && items_sent < calm + 100);
      random_vector();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_full_store();
    write_k(5'd16);
    while (n_stored < NUM_ENTRIES) store_vector($urandom_range(4, 5), 4'($urandom));
    for (int i = 0; i < 12; i++) begin
      if (i % 2 == 0) store_vector($urandom_range(1, 4), 4'($urandom));
      else query_vector($urandom_range(1, 4));
    end
  endtask

  task automatic test_backpressure();
    write_k(5'd3);
    hold_req = 1'b1;
    for (int i = 0; i < 15; i++) query_vector(2);
  endtask

  initial begin
    item_if.valid = 1'b0;
    item_if.cmd   = 1'b0;
    item_if.value = '0;
    item_if.label = '0;
    item_if.last  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    hold_req      = 1'b0;
    no_idle       = 1'b0;
    mismatches    = 0;
    items_sent    = 0;
    quiet_cycles  = 0;
    n_stored      = 0;
    elem_pos      = 0;
    energy_acc    = 0;
    k_setting     = 10;
    foreach (dot_acc[e]) begin
      dot_acc[e]     = 0;
      norm_mem[e]    = 0;
      class_mem[e]   = '0;
      written_len[e] = 0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_query();
    test_extremes();
    test_overlong_vector();
    test_k_settings();
    test_random_traffic();
    test_full_store();
    test_backpressure();
    drain();

    if (mismatches == 0 && verdict_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

### knn_cosine_vote_classifier.f
hdl/knn_pkg.sv
hdl/knn_intf.sv
hdl/knn_isqrt.sv
hdl/knn_cell.sv
hdl/knn_cosine_vote_classifier.sv
hdl/knn_checker.sv
tb/tb_knn_cosine_vote_classifier.sv
